// File: design/igcfd_pkg.sv
// ----------------------------------------------------------------------------
// igcfd_pkg
// Shared types and codes for the gyro calibration and fall detection block.
// ----------------------------------------------------------------------------
package igcfd_pkg;

   // calibration status codes
   typedef enum logic [1:0] {
      CAL_PENDING  = 2'd0,
      CAL_DONE     = 2'd1,
      CAL_REJECTED = 2'd2
   } cal_state_type;

   // fall classification codes
   typedef enum logic [1:0] {
      FALL_STANDING = 2'd0,
      FALL_FORWARD  = 2'd1,
      FALL_BACKWARD = 2'd2
   } fall_class_type;

   // configuration register indexes
   localparam logic [1:0] CSR_MOTION_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_FORWARD_LIMIT  = 2'd1;
   localparam logic [1:0] CSR_BACKWARD_LIMIT = 2'd2;

   // nominal gyro zero and accel ring fill value
   localparam logic [9:0]  GYRO_MID  = 10'd512;
   localparam logic [10:0] ACCEL_MID = 11'd512;

   // calibration view after the word now at the input
   typedef struct packed {
      cal_state_type status;
      logic [9:0]    center_fb;
      logic [9:0]    center_rl;
      logic          busy;
   } cal_view_type;

endpackage

// File: design/imu_gyro_calibration_and_fall_detect.sv
// ----------------------------------------------------------------------------
// imu_gyro_calibration_and_fall_detect
// Gyro bias calibration, gyro low-pass filter and accelerometer ring fall
// classifier, one sensor word in, one status word out.
// ----------------------------------------------------------------------------
// Takes one word per clock while req_ready is high; the result word is
// registered in the middle and then the output stage, and the filter and
// ring-sum updates are combinational. The one exception is the word that
// finishes calibration: the mean and variance test are worked out in two
// registered steps once the window fills, and req_ready stays low until both
// are done. The accel ring resets at once through per-entry valid bits, so
// there is no clearing pass after reset. Configuration is written through
// csr_write_enable / csr_index / csr_write_data, by the user only while idle (not enforced).
// ----------------------------------------------------------------------------
module imu_gyro_calibration_and_fall_detect #(
   parameter int CAL_WINDOW   = 100,
   parameter int ACCEL_WINDOW = 30
) (
   input  logic               clock,
   input  logic               reset,
   // configuration
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_write_data,
   // input words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_gyro_front_back,
   input  logic [9:0]         req_gyro_left_right,
   input  logic [9:0]         req_accel_front_back_raw,
   input  logic               req_sample_ok,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_calibration_state,
   output logic [9:0]         rsp_center_front_back,
   output logic [9:0]         rsp_center_left_right,
   output logic signed [18:0] rsp_filtered_front_back,
   output logic signed [18:0] rsp_filtered_left_right,
   output logic [10:0]        rsp_accel_average,
   output logic [1:0]         rsp_fall_class
);

   localparam int RSW = $clog2(1024 * ACCEL_WINDOW + 1);
   // floor(sum / ACCEL_WINDOW) by reciprocal
   localparam int RL  = $clog2(ACCEL_WINDOW);
   localparam int RSH = RSW + RL;
   localparam longint unsigned RM =
      ((64'd1 << RSH) + ACCEL_WINDOW - 1) / ACCEL_WINDOW;
   localparam logic [RSW:0] RM_V = (RSW + 1)'(RM);

   // configuration registers
   logic        motion_enable_ff;
   logic [10:0] forward_limit_ff, backward_limit_ff;

   igcfd_pkg::cal_view_type cal_view;
   logic               accept, motion, ring_step;
   logic signed [18:0] filt_fb_next, filt_rl_next;
   logic [RSW-1:0]     sum_next;

   // middle stage
   logic               b_valid_ff, b_classify_ff;
   logic [1:0]         b_status_ff;
   logic [9:0]         b_center_fb_ff, b_center_rl_ff;
   logic signed [18:0] b_filt_fb_ff, b_filt_rl_ff;
   logic [RSW-1:0]     b_sum_ff;

   // output stage
   logic               rsp_valid_ff;
   igcfd_pkg::fall_class_type fall_ff, fall_new;
   logic               advance, b_free;
   logic [2*RSW:0]     avg_prod;
   logic [10:0]        avg;

   // configuration writes; unknown index ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         motion_enable_ff  <= 1'b0;
         forward_limit_ff  <= 11'd390;
         backward_limit_ff <= 11'd580;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            igcfd_pkg::CSR_MOTION_ENABLE:  motion_enable_ff  <= csr_write_data[0];
            igcfd_pkg::CSR_FORWARD_LIMIT:  forward_limit_ff  <= csr_write_data;
            igcfd_pkg::CSR_BACKWARD_LIMIT: backward_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // handshake and pipeline flow
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign b_free    = !b_valid_ff || advance;
   assign req_ready = b_free && !cal_view.busy;
   assign accept    = req_valid && req_ready;
   assign motion    = accept && (cal_view.status == igcfd_pkg::CAL_DONE) && motion_enable_ff;
   assign ring_step = motion && req_sample_ok;

   igcfd_cal #(
      .CAL_WINDOW (CAL_WINDOW)
   ) u_cal (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .sample_ok (req_sample_ok),
      .gyro_fb   (req_gyro_front_back),
      .gyro_rl   (req_gyro_left_right),
      .cal_view  (cal_view)
   );

   igcfd_lowpass u_lowpass (
      .clock        (clock),
      .reset        (reset),
      .step         (ring_step),
      .gyro_fb      (req_gyro_front_back),
      .gyro_rl      (req_gyro_left_right),
      .center_fb    (cal_view.center_fb),
      .center_rl    (cal_view.center_rl),
      .filt_fb_next (filt_fb_next),
      .filt_rl_next (filt_rl_next)
   );

   igcfd_ring #(
      .ACCEL_WINDOW (ACCEL_WINDOW)
   ) u_ring (
      .clock     (clock),
      .reset     (reset),
      .step      (ring_step),
      .accel_raw (req_accel_front_back_raw),
      .sum_next  (sum_next)
   );

   // middle stage capture
   always_ff @(posedge clock) begin
      if (accept) begin
         b_status_ff    <= cal_view.status;
         b_center_fb_ff <= cal_view.center_fb;
         b_center_rl_ff <= cal_view.center_rl;
         b_filt_fb_ff   <= filt_fb_next;
         b_filt_rl_ff   <= filt_rl_next;
         b_sum_ff       <= sum_next;
         b_classify_ff  <= motion;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (accept) begin
         b_valid_ff <= 1'b1;
      end else if (advance) begin
         b_valid_ff <= 1'b0;
      end
   end

   // ring average and classification
   assign avg_prod = {{(RSW + 1){1'b0}}, b_sum_ff} * {{RSW{1'b0}}, RM_V};
   assign avg      = avg_prod[RSH +: 11];

   always_comb begin
      fall_new = fall_ff;
      if (b_classify_ff) begin
         if (avg < forward_limit_ff) begin
            fall_new = igcfd_pkg::FALL_FORWARD;
         end else if (avg > backward_limit_ff) begin
            fall_new = igcfd_pkg::FALL_BACKWARD;
         end else begin
            fall_new = igcfd_pkg::FALL_STANDING;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (b_valid_ff && advance) begin
         rsp_calibration_state   <= b_status_ff;
         rsp_center_front_back   <= b_center_fb_ff;
         rsp_center_left_right   <= b_center_rl_ff;
         rsp_filtered_front_back <= b_filt_fb_ff;
         rsp_filtered_left_right <= b_filt_rl_ff;
         rsp_accel_average       <= avg;
         rsp_fall_class          <= fall_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fall_ff      <= igcfd_pkg::FALL_STANDING;
      end else begin
         if (b_valid_ff && advance) begin
            rsp_valid_ff <= 1'b1;
            fall_ff      <= fall_new;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: design/igcfd_cal.sv
// ----------------------------------------------------------------------------
// igcfd_cal
// Gyro bias calibration: running sums over the window, then a precomputed
// mean and variance test that the finalizing word picks up.
// ----------------------------------------------------------------------------
module igcfd_cal #(
   parameter int CAL_WINDOW = 100
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     sample_ok,
   input  logic [9:0]               gyro_fb,
   input  logic [9:0]               gyro_rl,
   output igcfd_pkg::cal_view_type  cal_view
);

   localparam int CNTW = $clog2(CAL_WINDOW + 1);
   localparam int SUMW = $clog2(1023 * CAL_WINDOW + 1);
   localparam int SQW  = $clog2(1046529 * CAL_WINDOW + 1);
   localparam int TW   = $clog2(64'd1050625 * CAL_WINDOW * CAL_WINDOW) + 1;
   // floor(sum / CAL_WINDOW) by reciprocal
   localparam int CL   = $clog2(CAL_WINDOW);
   localparam int CSH  = SUMW + CL;
   localparam longint unsigned CM = ((64'd1 << CSH) + CAL_WINDOW - 1) / CAL_WINDOW;
   localparam logic [SUMW:0]   CM_V = (SUMW + 1)'(CM);
   localparam logic [TW-1:0]   FOURNN = TW'(64'd4 * CAL_WINDOW * CAL_WINDOW);
   localparam logic [TW-1:0]   WIN_T  = TW'(CAL_WINDOW);
   localparam logic [CNTW-1:0] WIN_C  = CNTW'(CAL_WINDOW);

   igcfd_pkg::cal_state_type status_ff;
   logic [CNTW-1:0] count_ff;
   logic [SUMW-1:0] sum_fb_ff, sum_rl_ff;
   logic [SQW-1:0]  sq_fb_ff, sq_rl_ff;
   logic [9:0]      center_fb_ff, center_rl_ff;

   logic [TW-1:0]   lhs_fb_ff, lhs_rl_ff, sqr_fb_ff, sqr_rl_ff;
   logic [9:0]      mean_fb_ff, mean_rl_ff;
   logic            ok1_ff, ok2_ff, pass_ff;

   logic            pending, full;
   logic [19:0]     g2_fb, g2_rl;
   logic [2*SUMW-1:0] sqr_fb, sqr_rl;
   logic [2*SUMW:0] prod_fb, prod_rl;

   assign pending = (status_ff != igcfd_pkg::CAL_DONE);
   assign full    = (count_ff == WIN_C);
   assign g2_fb   = gyro_fb * gyro_fb;
   assign g2_rl   = gyro_rl * gyro_rl;
   assign sqr_fb  = sum_fb_ff * sum_fb_ff;
   assign sqr_rl  = sum_rl_ff * sum_rl_ff;
   assign prod_fb = {{(SUMW + 1){1'b0}}, sum_fb_ff} * {{SUMW{1'b0}}, CM_V};
   assign prod_rl = {{(SUMW + 1){1'b0}}, sum_rl_ff} * {{SUMW{1'b0}}, CM_V};

   // view after the current word: finalize result when the window is full
   always_comb begin
      cal_view.busy      = pending && full && !ok2_ff;
      cal_view.status    = status_ff;
      cal_view.center_fb = center_fb_ff;
      cal_view.center_rl = center_rl_ff;
      if (pending && full) begin
         if (pass_ff) begin
            cal_view.status    = igcfd_pkg::CAL_DONE;
            cal_view.center_fb = mean_fb_ff;
            cal_view.center_rl = mean_rl_ff;
         end else begin
            cal_view.status    = igcfd_pkg::CAL_REJECTED;
            cal_view.center_fb = igcfd_pkg::GYRO_MID;
            cal_view.center_rl = igcfd_pkg::GYRO_MID;
         end
      end
   end

   // accumulate or finalize
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= igcfd_pkg::CAL_PENDING;
         count_ff     <= '0;
         sum_fb_ff    <= '0;
         sum_rl_ff    <= '0;
         sq_fb_ff     <= '0;
         sq_rl_ff     <= '0;
         center_fb_ff <= igcfd_pkg::GYRO_MID;
         center_rl_ff <= igcfd_pkg::GYRO_MID;
      end else if (step && pending) begin
         if (full) begin
            status_ff    <= cal_view.status;
            center_fb_ff <= cal_view.center_fb;
            center_rl_ff <= cal_view.center_rl;
            count_ff     <= '0;
            sum_fb_ff    <= '0;
            sum_rl_ff    <= '0;
            sq_fb_ff     <= '0;
            sq_rl_ff     <= '0;
         end else if (sample_ok) begin
            count_ff  <= count_ff + 1'b1;
            sum_fb_ff <= sum_fb_ff + SUMW'(gyro_fb);
            sum_rl_ff <= sum_rl_ff + SUMW'(gyro_rl);
            sq_fb_ff  <= sq_fb_ff + SQW'(g2_fb);
            sq_rl_ff  <= sq_rl_ff + SQW'(g2_rl);
         end
      end
   end

   // test precompute, stage 1: products and means
   always_ff @(posedge clock) begin
      lhs_fb_ff  <= TW'(sq_fb_ff) * WIN_T;
      lhs_rl_ff  <= TW'(sq_rl_ff) * WIN_T;
      sqr_fb_ff  <= TW'(sqr_fb);
      sqr_rl_ff  <= TW'(sqr_rl);
      mean_fb_ff <= prod_fb[CSH +: 10];
      mean_rl_ff <= prod_rl[CSH +: 10];
      // stage 2: N*sumsq - sum^2 < 4*N^2 on both axes
      pass_ff    <= (lhs_fb_ff < sqr_fb_ff + FOURNN) && (lhs_rl_ff < sqr_rl_ff + FOURNN);
   end

   // precompute valid flags; sums hold while the window is full
   always_ff @(posedge clock) begin
      if (reset) begin
         ok1_ff <= 1'b0;
         ok2_ff <= 1'b0;
      end else begin
         ok1_ff <= full;
         ok2_ff <= full && ok1_ff;
      end
   end

endmodule

// File: design/igcfd_lowpass.sv
// ----------------------------------------------------------------------------
// igcfd_lowpass
// First-order low-pass on both centered gyro axes, 0.92/0.08 mix, 8 fraction
// bits, rounded half up and clamped.
// ----------------------------------------------------------------------------
module igcfd_lowpass (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [9:0]         gyro_fb,
   input  logic [9:0]         gyro_rl,
   input  logic [9:0]         center_fb,
   input  logic [9:0]         center_rl,
   output logic signed [18:0] filt_fb_next,
   output logic signed [18:0] filt_rl_next
);

   // floor(num / 50): offset by 50 * 2^18, halve, multiply by ceil(2^29 / 25)
   localparam logic signed [25:0] LP_OFFSET = 26'sd13107200;
   localparam logic [24:0]        LP_RECIP  = 25'd21474837;
   localparam logic signed [20:0] LP_BIAS   = 21'sd262144;
   localparam logic signed [20:0] FILT_MAX  = 21'sd261888;

   logic signed [18:0] lp_fb_ff, lp_rl_ff;

   function automatic logic signed [18:0] lp_step(input logic signed [18:0] y,
                                                  input logic [9:0] g,
                                                  input logic [9:0] c);
      logic signed [10:0] d;
      logic signed [25:0] num;
      logic signed [25:0] u;
      logic [48:0]        prod;
      logic signed [20:0] q;
      d    = signed'({1'b0, g}) - signed'({1'b0, c});
      num  = 26'(y) * 26'sd46 + (26'(d) <<< 10) + 26'sd25;
      u    = num + LP_OFFSET;
      prod = {25'd0, u[24:1]} * {24'd0, LP_RECIP};
      q    = signed'({1'b0, prod[48:29]}) - LP_BIAS;
      if (q > FILT_MAX) begin
         q = FILT_MAX;
      end else if (q < -FILT_MAX) begin
         q = -FILT_MAX;
      end
      return q[18:0];
   endfunction

   always_comb begin
      filt_fb_next = lp_fb_ff;
      filt_rl_next = lp_rl_ff;
      if (step) begin
         filt_fb_next = lp_step(lp_fb_ff, gyro_fb, center_fb);
         filt_rl_next = lp_step(lp_rl_ff, gyro_rl, center_rl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_fb_ff <= '0;
         lp_rl_ff <= '0;
      end else begin
         lp_fb_ff <= filt_fb_next;
         lp_rl_ff <= filt_rl_next;
      end
   end

endmodule

// File: design/igcfd_ring.sv
// ----------------------------------------------------------------------------
// igcfd_ring
// Accelerometer ring memory with running sum. The entry at the next write
// position is prefetched so the sum update needs no read wait.
// ----------------------------------------------------------------------------
module igcfd_ring #(
   parameter int ACCEL_WINDOW = 30
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      step,
   input  logic [9:0]                                accel_raw,
   output logic [$clog2(1024 * ACCEL_WINDOW + 1)-1:0] sum_next
);

   localparam int PW  = (ACCEL_WINDOW > 1) ? $clog2(ACCEL_WINDOW) : 1;
   localparam int RSW = $clog2(1024 * ACCEL_WINDOW + 1);
   localparam logic [PW-1:0]  LAST_POS  = PW'(ACCEL_WINDOW - 1);
   localparam logic [RSW-1:0] SUM_RESET = RSW'(512 * ACCEL_WINDOW);

   logic [10:0]             ring_mem [ACCEL_WINDOW];
   logic [ACCEL_WINDOW-1:0] valid_ff;
   logic [PW-1:0]           pos_ff, pos_in;
   logic [RSW-1:0]          sum_ff;
   logic [10:0]             mem_q_ff, fwd_data_ff;
   logic                    fwd_ff, rd_valid_ff;
   logic [10:0]             value, old;

   assign value = 11'd1024 - {1'b0, accel_raw};

   // next write position
   always_comb begin
      pos_in = pos_ff;
      if (step) begin
         pos_in = (pos_ff == LAST_POS) ? '0 : pos_ff + 1'b1;
      end
   end

   // oldest entry: forwarded write, stored value, or the fill value
   assign old = fwd_ff ? fwd_data_ff : (rd_valid_ff ? mem_q_ff : igcfd_pkg::ACCEL_MID);

   assign sum_next = step ? sum_ff - RSW'(old) + RSW'(value) : sum_ff;

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (step) begin
         ring_mem[pos_ff] <= value;
      end
      mem_q_ff    <= ring_mem[pos_in];
      fwd_data_ff <= value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         pos_ff      <= '0;
         sum_ff      <= SUM_RESET;
         fwd_ff      <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            valid_ff[pos_ff] <= 1'b1;
         end
         pos_ff      <= pos_in;
         sum_ff      <= sum_next;
         fwd_ff      <= step && (pos_in == pos_ff);
         rd_valid_ff <= valid_ff[pos_in];
      end
   end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gyro calibration and fall detection block.
// Sensor words go in over a valid/ready channel with bursty gaps while the
// result channel stalls on its own pattern. A tracker object mirrors the
// calibration windows, the low-pass filters and the accelerometer ring,
// queues the status word each input should produce and compares every
// returned word field by field. Calibration is first rejected several ways
// (noisy data, one axis exactly at the variance limit) and then passed.
// After that, phases with different enable and limit settings drive the
// filter and fall classifier.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WINDOW_LEN  = 100;
   localparam int RING_LEN    = 30;
   localparam int FILT_LIMIT  = 261888;
   localparam int POST_WORDS  = 220;
   localparam int CYCLE_LIMIT = 400000;

   // index with no register behind it
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // shapes of the gyro samples fed into one calibration window
   typedef enum int {WIN_NOISY, WIN_QUIET, WIN_EDGE, WIN_NEAR} window_shape_type;
   // gyro and accel patterns of one motion segment
   typedef enum int {GYRO_ANY, GYRO_RAIL, GYRO_CENTERED, GYRO_HOLD} gyro_pattern_type;
   typedef enum int {ACCEL_ANY, ACCEL_LEVEL, ACCEL_JITTER} accel_pattern_type;

   typedef struct packed {
      igcfd_pkg::cal_state_type  status;
      logic [9:0]                center_fb;
      logic [9:0]                center_rl;
      logic signed [18:0]        filt_fb;
      logic signed [18:0]        filt_rl;
      logic [10:0]               accel_avg;
      igcfd_pkg::fall_class_type fall;
   } tick_status_type;

   // tracks calibration, filter and ring state; queues expected status words
   class tick_result_tracker;
      tick_status_type           status_due[$];
      int unsigned               mismatch_count;
      int unsigned               result_index;
      bit                        motion_on;
      int unsigned               forward_limit;
      int unsigned               backward_limit;
      igcfd_pkg::cal_state_type  cal_state;
      int unsigned               window_count;
      longint                    sum_fb, sum_rl, sq_fb, sq_rl;
      logic [9:0]                mid_fb, mid_rl;
      longint                    smooth_fb, smooth_rl;
      int unsigned               ring [RING_LEN];
      int unsigned               ring_at;
      int unsigned               ring_total;
      igcfd_pkg::fall_class_type fall_now;

      function new();
         mismatch_count = 0;
         result_index   = 0;
         motion_on      = 1'b0;
         forward_limit  = 390;
         backward_limit = 580;
         cal_state      = igcfd_pkg::CAL_PENDING;
         window_count   = 0;
         sum_fb = 0; sum_rl = 0; sq_fb = 0; sq_rl = 0;
         mid_fb = igcfd_pkg::GYRO_MID;
         mid_rl = igcfd_pkg::GYRO_MID;
         smooth_fb = 0;
         smooth_rl = 0;
         foreach (ring[i]) ring[i] = 32'(igcfd_pkg::ACCEL_MID);
         ring_at    = 0;
         ring_total = 32'(igcfd_pkg::ACCEL_MID) * RING_LEN;
         fall_now   = igcfd_pkg::FALL_STANDING;
      endfunction

      function void set_register(logic [1:0] idx, logic [10:0] data);
         case (idx)
            igcfd_pkg::CSR_MOTION_ENABLE:  motion_on = data[0];
            igcfd_pkg::CSR_FORWARD_LIMIT:  forward_limit = {21'd0, data};
            igcfd_pkg::CSR_BACKWARD_LIMIT: backward_limit = {21'd0, data};
            default: ;
         endcase
      endfunction

      // std dev below 2: N*sumsq - sum^2 < 4*N^2
      function bit is_steady(longint s, longint sq);
         longint lhs, s2;
         lhs = WINDOW_LEN * sq;
         s2  = s * s;
         if (lhs < s2) return 1'b1;
         return (lhs - s2) < 4 * WINDOW_LEN * WINDOW_LEN;
      endfunction

      // 0.92/0.08 mix with 8 fraction bits, rounded half up, then clamped
      function longint smooth_step(longint y, longint d);
         longint num, q;
         num = 2 * (23 * y + 512 * d) + 25;
         if (num >= 0) q = num / 50;
         else q = -((-num + 49) / 50);
         if (q > FILT_LIMIT) q = FILT_LIMIT;
         if (q < -FILT_LIMIT) q = -FILT_LIMIT;
         return q;
      endfunction

      function void take_tick(logic [9:0] gfb, logic [9:0] grl, logic [9:0] acc,
                              logic ok);
         tick_status_type want;
         int unsigned     v, avg;
         // calibration window: gather, or close it on the word after it fills
         if (cal_state != igcfd_pkg::CAL_DONE) begin
            if (window_count < WINDOW_LEN) begin
               if (ok) begin
                  sum_fb += gfb;
                  sum_rl += grl;
                  sq_fb  += longint'(gfb) * gfb;
                  sq_rl  += longint'(grl) * grl;
                  window_count++;
               end
            end else begin
               if (is_steady(sum_fb, sq_fb) && is_steady(sum_rl, sq_rl)) begin
                  mid_fb    = 10'(sum_fb / WINDOW_LEN);
                  mid_rl    = 10'(sum_rl / WINDOW_LEN);
                  cal_state = igcfd_pkg::CAL_DONE;
               end else begin
                  mid_fb    = igcfd_pkg::GYRO_MID;
                  mid_rl    = igcfd_pkg::GYRO_MID;
                  cal_state = igcfd_pkg::CAL_REJECTED;
               end
               window_count = 0;
               sum_fb = 0; sum_rl = 0; sq_fb = 0; sq_rl = 0;
            end
         end
         // filters and ring move only on valid words; class updates regardless
         if (cal_state == igcfd_pkg::CAL_DONE && motion_on) begin
            if (ok) begin
               smooth_fb = smooth_step(smooth_fb, longint'(gfb) - longint'(mid_fb));
               smooth_rl = smooth_step(smooth_rl, longint'(grl) - longint'(mid_rl));
               v = 1024 - acc;
               ring_total = ring_total - ring[ring_at] + v;
               ring[ring_at] = v;
               ring_at = (ring_at + 1 >= RING_LEN) ? 0 : ring_at + 1;
            end
            avg = ring_total / RING_LEN;
            if (avg < forward_limit) fall_now = igcfd_pkg::FALL_FORWARD;
            else if (avg > backward_limit) fall_now = igcfd_pkg::FALL_BACKWARD;
            else fall_now = igcfd_pkg::FALL_STANDING;
         end
         want.status    = cal_state;
         want.center_fb = mid_fb;
         want.center_rl = mid_rl;
         want.filt_fb   = smooth_fb[18:0];
         want.filt_rl   = smooth_rl[18:0];
         want.accel_avg = 11'(ring_total / RING_LEN);
         want.fall      = fall_now;
         status_due     = {status_due, want};
      endfunction

      task flag_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= 40) $display("@%0t mismatch: %s", $time, what);
      endtask

      task check_field(string name, logic [18:0] got, logic [18:0] want);
         if (got !== want)
            flag_mismatch($sformatf("word %0d %s: got 0x%0h, want 0x%0h",
                                    result_index, name, got, want));
      endtask

      task match_status(tick_status_type got);
         tick_status_type want;
         if (status_due.size() == 0) begin
            flag_mismatch($sformatf("word %0d: result with nothing outstanding",
                                    result_index));
         end else begin
            want = status_due.pop_front();
            check_field("calibration_state", 19'(got.status), 19'(want.status));
            check_field("center_front_back", 19'(got.center_fb), 19'(want.center_fb));
            check_field("center_left_right", 19'(got.center_rl), 19'(want.center_rl));
            check_field("filtered_front_back", got.filt_fb, want.filt_fb);
            check_field("filtered_left_right", got.filt_rl, want.filt_rl);
            check_field("accel_average", 19'(got.accel_avg), 19'(want.accel_avg));
            check_field("fall_class", 19'(got.fall), 19'(want.fall));
         end
         result_index++;
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [1:0]         csr_index;
   logic [10:0]        csr_write_data;
   logic               req_valid;
   logic               req_ready;
   logic [9:0]         req_gyro_front_back;
   logic [9:0]         req_gyro_left_right;
   logic [9:0]         req_accel_front_back_raw;
   logic               req_sample_ok;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_calibration_state;
   logic [9:0]         rsp_center_front_back;
   logic [9:0]         rsp_center_left_right;
   logic signed [18:0] rsp_filtered_front_back;
   logic signed [18:0] rsp_filtered_left_right;
   logic [10:0]        rsp_accel_average;
   logic [1:0]         rsp_fall_class;

   tick_result_tracker tracker = new();
   tick_status_type    seen_status;
   int                 burst_left = 0;
   int                 ok_sent = 0;
   int                 ready_run = 0;
   int                 cycle_count = 0;

   imu_gyro_calibration_and_fall_detect uut (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_gyro_front_back      (req_gyro_front_back),
      .req_gyro_left_right      (req_gyro_left_right),
      .req_accel_front_back_raw (req_accel_front_back_raw),
      .req_sample_ok            (req_sample_ok),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_calibration_state    (rsp_calibration_state),
      .rsp_center_front_back    (rsp_center_front_back),
      .rsp_center_left_right    (rsp_center_left_right),
      .rsp_filtered_front_back  (rsp_filtered_front_back),
      .rsp_filtered_left_right  (rsp_filtered_left_right),
      .rsp_accel_average        (rsp_accel_average),
      .rsp_fall_class           (rsp_fall_class)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[imu_gyro_calibration_and_fall_detect] ERROR");
      $finish;
   end

   // receiver: runs of ready and runs of stall
   always @(posedge clock) begin
      if (ready_run == 0) begin
         if ($urandom_range(0, 9) < 6) begin
            rsp_ready <= 1'b1;
            ready_run <= int'($urandom_range(1, 40));
         end else begin
            rsp_ready <= 1'b0;
            ready_run <= int'($urandom_range(1, 6));
         end
      end else begin
         ready_run <= ready_run - 1;
      end
   end

   // both handshakes sampled at the edge: note inputs, then check results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.take_tick(req_gyro_front_back, req_gyro_left_right,
                              req_accel_front_back_raw, req_sample_ok);
         if (rsp_valid && rsp_ready) begin
            seen_status.status    = igcfd_pkg::cal_state_type'(rsp_calibration_state);
            seen_status.center_fb = rsp_center_front_back;
            seen_status.center_rl = rsp_center_left_right;
            seen_status.filt_fb   = rsp_filtered_front_back;
            seen_status.filt_rl   = rsp_filtered_left_right;
            seen_status.accel_avg = rsp_accel_average;
            seen_status.fall      = igcfd_pkg::fall_class_type'(rsp_fall_class);
            tracker.match_status(seen_status);
         end
      end
   end

   function automatic logic [9:0] clip10(int v);
      if (v < 0) return 10'd0;
      if (v > 1023) return 10'd1023;
      return v[9:0];
   endfunction

   // one gyro sample of a calibration window; idx counts valid samples so far
   function automatic logic [9:0] window_value(window_shape_type shape, int c, int idx);
      case (shape)
         WIN_NOISY: return 10'($urandom_range(0, 1023));
         WIN_QUIET: return clip10(c + int'($urandom_range(0, 1)));
         // half at c-2, half at c+2: variance exactly at the limit
         WIN_EDGE:  return clip10((idx % 2) ? c + 2 : c - 2);
         // two at c, the rest split at c-2 / c+2: just under the limit
         default:   return clip10((idx < 2) ? c : ((idx % 2) ? c + 2 : c - 2));
      endcase
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [10:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // sender: bursts of random length with random gaps between them
   task automatic send_word(logic [9:0] gfb, logic [9:0] grl, logic [9:0] acc,
                            logic ok);
      int gap;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 24));
         gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid                <= 1'b1;
      req_gyro_front_back      <= gfb;
      req_gyro_left_right      <= grl;
      req_accel_front_back_raw <= acc;
      req_sample_ok            <= ok;
      do @(posedge clock); while (!req_ready);
      if (ok) ok_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.status_due.size() != 0);
   endtask

   // fill a window with valid samples (some invalid words mixed in), then
   // send the word that closes it
   task automatic run_cal_window(window_shape_type shape_fb, int c_fb,
                                 window_shape_type shape_rl, int c_rl);
      while (ok_sent < WINDOW_LEN) begin
         if ($urandom_range(0, 9) == 0)
            send_word(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)), 1'b0);
         else
            send_word(window_value(shape_fb, c_fb, ok_sent),
                      window_value(shape_rl, c_rl, ok_sent),
                      10'($urandom_range(0, 1023)), 1'b1);
      end
      send_word(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      ok_sent = 0;
   endtask

   // motion traffic in segments: gyro rails and holds, accel levels that
   // push the ring average across the fall limits
   task automatic run_motion(int count);
      int                seg_left;
      int                level;
      int                jit;
      gyro_pattern_type  gyro_mode;
      accel_pattern_type accel_mode;
      logic [9:0]        hold_fb, hold_rl, gfb, grl, acc;
      seg_left = 0;
      repeat (count) begin
         if (seg_left == 0) begin
            gyro_mode  = gyro_pattern_type'($urandom_range(0, 3));
            accel_mode = accel_pattern_type'($urandom_range(0, 2));
            seg_left   = (gyro_mode == GYRO_RAIL) ? int'($urandom_range(60, 200))
                                                  : int'($urandom_range(8, 60));
            if (gyro_mode == GYRO_RAIL) begin
               hold_fb = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
               hold_rl = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            end else begin
               hold_fb = 10'($urandom_range(0, 1023));
               hold_rl = 10'($urandom_range(0, 1023));
            end
            case ($urandom_range(0, 3))
               0:       level = 0;
               1:       level = 1023;
               default: level = int'($urandom_range(0, 1023));
            endcase
         end
         seg_left--;
         case (gyro_mode)
            GYRO_ANY: begin
               gfb = 10'($urandom_range(0, 1023));
               grl = 10'($urandom_range(0, 1023));
            end
            GYRO_CENTERED: begin
               jit = int'($urandom_range(0, 24));
               gfb = clip10(int'(tracker.mid_fb) + jit - 12);
               jit = int'($urandom_range(0, 24));
               grl = clip10(int'(tracker.mid_rl) + jit - 12);
            end
            default: begin
               gfb = hold_fb;
               grl = hold_rl;
            end
         endcase
         jit = int'($urandom_range(0, 32));
         case (accel_mode)
            ACCEL_ANY:   acc = 10'($urandom_range(0, 1023));
            ACCEL_LEVEL: acc = clip10(level);
            default:     acc = clip10(level + jit - 16);
         endcase
         send_word(gfb, grl, acc, $urandom_range(0, 9) != 0);
      end
   endtask

   initial begin
      logic [10:0] enable_word;
      reset                    <= 1'b1;
      csr_write_enable         <= 1'b0;
      csr_index                <= igcfd_pkg::CSR_MOTION_ENABLE;
      csr_write_data           <= 11'd0;
      req_valid                <= 1'b0;
      req_gyro_front_back      <= 10'd0;
      req_gyro_left_right      <= 10'd0;
      req_accel_front_back_raw <= 10'd0;
      req_sample_ok            <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // enabled up front so the word closing calibration already filters
      write_reg(igcfd_pkg::CSR_MOTION_ENABLE, 11'd1);
      write_reg(igcfd_pkg::CSR_FORWARD_LIMIT, 11'd390);
      write_reg(igcfd_pkg::CSR_BACKWARD_LIMIT, 11'd580);

      // field extremes and invalid words while calibration is pending
      send_word(10'd0, 10'd0, 10'd0, 1'b1);
      send_word(10'd1023, 10'd1023, 10'd1023, 1'b1);
      send_word(10'd0, 10'd1023, 10'd512, 1'b1);
      send_word(10'd1023, 10'd0, 10'd0, 1'b1);
      send_word(10'd512, 10'd512, 10'd1023, 1'b0);
      send_word(10'd1023, 10'd1023, 10'd0, 1'b0);
      send_word(10'd0, 10'd0, 10'd1023, 1'b0);
      send_word(10'd512, 10'd512, 10'd512, 1'b1);
      send_word(10'd1, 10'd1022, 10'd511, 1'b1);
      send_word(10'd1022, 10'd1, 10'd513, 1'b1);
      send_word(10'd511, 10'd513, 10'd1, 1'b0);
      send_word(10'd513, 10'd511, 10'd1022, 1'b1);

      // rejected: noisy; then one axis exactly at the variance limit each way
      run_cal_window(WIN_NOISY, 0, WIN_NOISY, 0);
      run_cal_window(WIN_QUIET, int'($urandom_range(0, 1022)),
                     WIN_EDGE, int'($urandom_range(2, 1021)));
      run_cal_window(WIN_EDGE, int'($urandom_range(2, 1021)),
                     WIN_QUIET, int'($urandom_range(0, 1022)));
      // passes just under the limit, with centers near both rails
      run_cal_window(WIN_NEAR, 1021, WIN_QUIET, 0);

      run_motion(POST_WORDS);

      // disabled: filter, ring and class hold
      drain();
      write_reg(igcfd_pkg::CSR_MOTION_ENABLE, 11'd0);
      write_reg(igcfd_pkg::CSR_FORWARD_LIMIT, 11'($urandom_range(200, 500)));
      write_reg(igcfd_pkg::CSR_BACKWARD_LIMIT, 11'($urandom_range(500, 800)));
      run_motion(POST_WORDS);

      // limits wide open: always standing
      drain();
      enable_word = 11'($urandom);
      enable_word[0] = 1'b1;
      write_reg(igcfd_pkg::CSR_MOTION_ENABLE, enable_word);
      write_reg(igcfd_pkg::CSR_FORWARD_LIMIT, 11'd0);
      write_reg(igcfd_pkg::CSR_BACKWARD_LIMIT, 11'd1024);
      run_motion(POST_WORDS);

      // limits crossed: forward unless the ring sits at full scale
      drain();
      write_reg(igcfd_pkg::CSR_FORWARD_LIMIT, 11'd1024);
      write_reg(igcfd_pkg::CSR_BACKWARD_LIMIT, 11'd0);
      run_motion(POST_WORDS);

      // a write to the unused index must change nothing
      drain();
      write_reg(CSR_UNUSED, 11'h7ff);
      write_reg(igcfd_pkg::CSR_FORWARD_LIMIT, 11'($urandom_range(300, 500)));
      write_reg(igcfd_pkg::CSR_BACKWARD_LIMIT, 11'($urandom_range(500, 700)));
      run_motion(POST_WORDS);

      // equal limits
      drain();
      enable_word = 11'($urandom_range(400, 600));
      write_reg(igcfd_pkg::CSR_FORWARD_LIMIT, enable_word);
      write_reg(igcfd_pkg::CSR_BACKWARD_LIMIT, enable_word);
      run_motion(POST_WORDS);

      drain();
      repeat (10) @(posedge clock);
      if (tracker.mismatch_count == 0) begin
         $display("[imu_gyro_calibration_and_fall_detect] OK");
      end else begin
         $display("[imu_gyro_calibration_and_fall_detect] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/igcfd_pkg.sv
design/igcfd_cal.sv
design/igcfd_lowpass.sv
design/igcfd_ring.sv
design/imu_gyro_calibration_and_fall_detect.sv
tb/sv/testbench.sv
